>>> src/dfs_pkg.sv
// Package with shared types and constants for the depth-first topological sort core.
`timescale 1ns / 1ps
package dfs_pkg;
  localparam int NODES = 32;
  localparam int EDGES_PER_NODE = 32;
  localparam int NODE_W = $clog2(NODES);
  localparam int EIDX_W = $clog2(EDGES_PER_NODE);
  localparam int CNT_W = $clog2(EDGES_PER_NODE + 1);
  localparam int SP_W = $clog2(NODES + 1);
  localparam int DONE_W = $clog2(NODES + 1);

  localparam logic [1:0] CMD_MARK   = 2'd0;
  localparam logic [1:0] CMD_EDGE   = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] node_a;
    logic [4:0] node_b;
  } in_word_t;

  typedef struct packed {
    logic [4:0] node;
    logic       empty_res;
    logic       last;
    logic       edge_dropped;
  } out_word_t;
endpackage

>>> src/dfs_topological_sort_core.sv
// Top level of the depth-first topological sort core.
// Usage: words arrive on in_valid/in_ready/in_data and results leave on
// out_valid/out_ready/out_data, both with a valid and ready handshake.
// A mark word flags a node as present; an edge word appends a successor to
// the source node's list in arrival order.
// A run word starts the search: nodes are walked in index order, successors
// in insertion order, and each finished node is stored in a finish memory.
// Following one edge passes through the stack top, an edge memory read and
// then a visited check; a node is finished when it is popped at the stack top.
// Words then leave one per cycle while the receiver is ready. The edge list
// lives in one synchronous memory with a registered read port.
// Results come out in reverse finish order, with last set on the final word.
// A run with nothing present gives one word with empty_res set.
// Input is not taken while a run is walking or emitting. When the receiver
// stalls, the output register holds its word and emission waits.
// Reset clears marks, counts, visited bits and the overflow flag at once;
// the edge memory needs no clearing since only entries below a count are read.
// When the final word is taken, all marks, counts, visited bits and the overflow flag are cleared together.
`timescale 1ns / 1ps
module dfs_topological_sort_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dfs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dfs_pkg::out_word_t out_data
);
  import dfs_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SCAN, ST_TOP, ST_READ, ST_CHECK, ST_EMIT, ST_WAIT
  } state_t;

  state_t state;

  logic [NODES-1:0] present;
  logic [NODES-1:0] visited;
  logic [CNT_W-1:0] counts [NODES];
  logic overflow;

  // Edge list memory: one write port, one registered read port.
  logic [NODE_W-1:0] edge_mem [NODES*EDGES_PER_NODE];
  logic [NODE_W-1:0] edge_rd;
  logic              edge_we;
  logic [NODE_W+EIDX_W-1:0] edge_waddr, edge_raddr;
  logic [NODE_W-1:0] edge_wdata;

  // Search stack: node and next edge index, read only at the top.
  logic [NODE_W-1:0] stk_node [NODES];
  logic [CNT_W-1:0]  stk_next [NODES];
  logic [SP_W-1:0]   sp;

  // Finish order memory.
  logic [NODE_W-1:0] fin_mem [NODES];
  logic [DONE_W-1:0] done;

  logic [NODE_W-1:0] scan;
  logic [NODE_W-1:0] cur_u;
  logic [CNT_W-1:0]  cur_idx;

  logic in_fire, out_fire;
  assign in_ready = (state == ST_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    edge_we    = in_fire && in_data.command == CMD_EDGE &&
                 counts[in_data.node_a] < CNT_W'(EDGES_PER_NODE);
    edge_waddr = {in_data.node_a, counts[in_data.node_a][EIDX_W-1:0]};
    edge_wdata = in_data.node_b;
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rd <= edge_mem[edge_raddr];
  end

  assign edge_raddr = {cur_u, cur_idx[EIDX_W-1:0]};

  logic [NODE_W-1:0] top_node;
  logic [CNT_W-1:0]  top_next;
  logic [SP_W-1:0]   sp_m1;
  logic [DONE_W-1:0] done_m1;
  assign sp_m1    = sp - SP_W'(1);
  assign done_m1  = done - DONE_W'(1);
  assign top_node = stk_node[sp_m1[NODE_W-1:0]];
  assign top_next = stk_next[sp_m1[NODE_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      present   <= '0;
      visited   <= '0;
      overflow  <= 1'b0;
      sp        <= '0;
      done      <= '0;
      scan      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        counts[i] <= '0;
      end
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_fire) begin
            case (in_data.command)
              CMD_MARK: present[in_data.node_a] <= 1'b1;
              CMD_EDGE: begin
                if (edge_we) begin
                  counts[in_data.node_a] <= counts[in_data.node_a] + CNT_W'(1);
                end else begin
                  overflow <= 1'b1;
                end
              end
              CMD_RUN: begin
                scan  <= '0;
                done  <= '0;
                sp    <= '0;
                state <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (present[scan] && !visited[scan]) begin
            visited[scan] <= 1'b1;
            stk_node[0]   <= scan;
            stk_next[0]   <= '0;
            sp            <= SP_W'(1);
            state         <= ST_TOP;
          end else if (scan == NODE_W'(NODES - 1)) begin
            state <= ST_EMIT;
          end else begin
            scan <= scan + NODE_W'(1);
          end
        end
        ST_TOP: begin
          if (sp == '0) begin
            if (scan == NODE_W'(NODES - 1)) begin
              state <= ST_EMIT;
            end else begin
              scan  <= scan + NODE_W'(1);
              state <= ST_SCAN;
            end
          end else if (top_next < counts[top_node]) begin
            cur_u   <= top_node;
            cur_idx <= top_next;
            stk_next[sp_m1[NODE_W-1:0]] <= top_next + CNT_W'(1);
            state   <= ST_READ;
          end else begin
            sp <= sp_m1;
            fin_mem[done[NODE_W-1:0]] <= top_node;
            done <= done + DONE_W'(1);
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!visited[edge_rd] && sp < SP_W'(NODES)) begin
            visited[edge_rd] <= 1'b1;
            stk_node[sp[NODE_W-1:0]] <= edge_rd;
            stk_next[sp[NODE_W-1:0]] <= '0;
            sp <= sp + SP_W'(1);
          end
          state <= ST_TOP;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.edge_dropped <= overflow;
            if (done == '0) begin
              out_data.node      <= '0;
              out_data.empty_res <= 1'b1;
              out_data.last      <= 1'b1;
              state              <= ST_WAIT;
            end else begin
              out_data.empty_res <= 1'b0;
              out_data.node      <= fin_mem[done_m1[NODE_W-1:0]];
              out_data.last      <= (done == DONE_W'(1));
              done               <= done_m1;
              if (done == DONE_W'(1)) begin
                state <= ST_WAIT;
              end
            end
          end
        end
        ST_WAIT: begin
          if (out_fire) begin
            out_valid <= 1'b0;
            present   <= '0;
            visited   <= '0;
            overflow  <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
              counts[i] <= '0;
            end
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_in_when_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> !in_ready) else $error("input taken during run");
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(NODES)) else $error("stack overflow");
  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    done <= DONE_W'(NODES)) else $error("finish count overflow");
  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT && out_fire |=> present == '0 && visited == '0)
    else $error("stores not cleared after run");
`endif
endmodule
